// ===== rtl/lpr_pkg.sv =====
// types and constants shared by the longest-prefix route lookup design
`default_nettype none
package lpr_pkg;

	localparam int unsigned CFG_W  = 11;
	localparam int unsigned SLOT_W = 10;
	localparam int unsigned PORT_W = 4;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [SLOT_W-1:0] entry_index;
		logic [31:0]       entry_prefix;
		logic [31:0]       entry_mask;
		logic [31:0]       entry_next_hop;
		logic [PORT_W-1:0] entry_port;
		logic [31:0]       lookup_address;
	} lpr_req_t;

	typedef struct packed {
		logic              found;
		logic [31:0]       next_hop_address;
		logic [PORT_W-1:0] out_port;
	} lpr_rsp_t;

	typedef struct packed {
		logic [31:0]       prefix;
		logic [31:0]       mask;
		logic [31:0]       hop_addr;
		logic [PORT_W-1:0] port;
	} lpr_entry_t;

	typedef enum logic [1:0] {
		LPR_IDLE,
		LPR_SCAN,
		LPR_DRAIN,
		LPR_DONE
	} lpr_state_t;

endpackage
`default_nettype wire

// ===== rtl/lpr_table.sv =====
// route entry memory, one write port and one registered read port
`default_nettype none
module lpr_table #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned IDX_W = 10
) (
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [IDX_W-1:0]    waddr,
	input  wire lpr_pkg::lpr_entry_t wdata,
	input  wire logic                re,
	input  wire logic [IDX_W-1:0]    raddr,
	output      lpr_pkg::lpr_entry_t rdata
);
	import lpr_pkg::*;

	lpr_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lpr_ctrl.sv =====
// item handshake, table scan sequencer, best-route tracking and result register
`default_nettype none
module lpr_ctrl #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned IDX_W = 10,
	parameter int unsigned CNT_W = 11
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output      logic                req_stall,
	input  wire lpr_pkg::lpr_req_t   req,
	output      logic                rsp_valid,
	input  wire logic                rsp_stall,
	output      lpr_pkg::lpr_rsp_t   rsp,
	input  wire logic [CNT_W-1:0]    count,
	output      logic                mem_we,
	output      logic [IDX_W-1:0]    mem_waddr,
	output      lpr_pkg::lpr_entry_t mem_wdata,
	output      logic                mem_re,
	output      logic [IDX_W-1:0]    mem_raddr,
	input  wire lpr_pkg::lpr_entry_t mem_rdata
);
	import lpr_pkg::*;

	lpr_state_t        state_q, state_d;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       addr_q;
	logic              valid_s1;
	logic              hit_q;
	logic [31:0]       best_mask_q;
	logic [31:0]       best_hop_q;
	logic [PORT_W-1:0] best_port_q;
	logic              rsp_valid_q;
	lpr_rsp_t          rsp_q;

	logic accept;
	logic start;
	logic last;
	logic load;
	logic match;
	logic better;

	assign accept = req_valid && !req_stall;
	assign start  = accept && (req.mode == MODE_LOOKUP);
	assign last   = ({1'b0, idx_q} + {{IDX_W{1'b0}}, 1'b1}) == (IDX_W + 1)'(cnt_q);
	assign match  = (addr_q & mem_rdata.mask) == mem_rdata.prefix;
	assign better = !hit_q || (mem_rdata.mask > best_mask_q);

	assign mem_waddr = IDX_W'(req.entry_index);
	assign mem_wdata = '{prefix: req.entry_prefix, mask: req.entry_mask,
		hop_addr: req.entry_next_hop, port: req.entry_port};
	assign mem_raddr = idx_q;

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		load      = 1'b0;
		case (state_q)
			LPR_IDLE: begin
				req_stall = 1'b0;
				if (req_valid && req.mode == MODE_WRITE) begin
					mem_we = (32'(req.entry_index) < DEPTH);
				end
				if (start) begin
					state_d = (count == '0) ? LPR_DONE : LPR_SCAN;
				end
			end
			LPR_SCAN: begin
				mem_re = 1'b1;
				if (last) begin
					state_d = LPR_DRAIN;
				end
			end
			LPR_DRAIN: begin
				state_d = LPR_DONE;
			end
			LPR_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load    = 1'b1;
					state_d = LPR_IDLE;
				end
			end
			default: begin
				state_d = LPR_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= LPR_IDLE;
			valid_s1    <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= mem_re;
			if (start) begin
				hit_q <= 1'b0;
			end else if (valid_s1 && match && better) begin
				hit_q <= 1'b1;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			idx_q       <= '0;
			cnt_q       <= count;
			addr_q      <= req.lookup_address;
			best_mask_q <= '0;
			best_hop_q  <= '0;
			best_port_q <= '0;
		end else begin
			if (mem_re) begin
				idx_q <= idx_q + 1'b1;
			end
			if (valid_s1 && match && better) begin
				best_mask_q <= mem_rdata.mask;
				best_hop_q  <= mem_rdata.hop_addr;
				best_port_q <= mem_rdata.port;
			end
		end
		if (load) begin
			rsp_q <= '{found: hit_q, next_hop_address: best_hop_q, out_port: best_port_q};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// ===== rtl/longest_prefix_route_lookup_core.sv =====
// top level of the IPv4 longest-prefix route lookup engine
// a write item updates the route memory at its accept edge
// a lookup item reads one entry per cycle through the single read port, then passes one drain
// state and one result state; with no entries in use it goes straight to the result state
// the result register lets the next item enter while a result still waits
// reset clears control state and entries_in_use; route memory contents are kept
`default_nettype none
module longest_prefix_route_lookup_core #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	output      logic                      req_stall,
	input  wire lpr_pkg::lpr_req_t         req,
	output      logic                      rsp_valid,
	input  wire logic                      rsp_stall,
	output      lpr_pkg::lpr_rsp_t         rsp,
	input  wire logic                      cfg_we,
	input  wire logic [lpr_pkg::CFG_W-1:0] cfg_data
);
	import lpr_pkg::*;

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = IDX_W + 1;

	logic [CNT_W-1:0] count_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	lpr_entry_t       mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	lpr_entry_t       mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= (32'(cfg_data) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cfg_data);
		end
	end

	lpr_table #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lpr_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.count     (count_q),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	a_write_only_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !req_stall && !mem_re)
		else $error("route write during a scan");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (32'(mem_raddr) < TABLE_DEPTH) && (CNT_W'(mem_raddr) < count_q))
		else $error("scan read beyond entries in use");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.next_hop_address == '0 && rsp.out_port == '0)
		else $error("miss result carries route data");

	a_stall_while_scanning: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> req_stall)
		else $error("item accepted during a scan");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// testbench for the longest-prefix route lookup core: table writes, lookups, checked in order
`timescale 1ns / 100ps
module tb;
	import lpr_pkg::*;

	localparam int unsigned DEPTH = 1024;
	localparam int unsigned FILL_SLOTS = 160;
	localparam int unsigned HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	lpr_req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	lpr_rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	longest_prefix_route_lookup_core #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	lpr_entry_t route_table [DEPTH];
	int unsigned route_count = 0;
	lpr_rsp_t expected_routes [$];
	logic [31:0] base_pool [8];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_asks = 0;
	int unsigned hold_taken = 0;
	int unsigned hold_left = 0;

	int unsigned mismatches = 0;
	int unsigned writes_sent = 0;
	int unsigned lookups_sent = 0;
	int unsigned hits_seen = 0;
	int unsigned cfg_writes = 0;

	function automatic lpr_rsp_t predict_route(logic [31:0] addr);
		lpr_rsp_t best;
		logic [31:0] best_mask;
		int unsigned span;
		best = '0;
		best_mask = '0;
		span = (route_count > DEPTH) ? DEPTH : route_count;
		for (int unsigned i = 0; i < span; i++) begin
			if ((addr & route_table[i].mask) == route_table[i].prefix &&
			    (!best.found || route_table[i].mask > best_mask)) begin
				best.found = 1'b1;
				best.next_hop_address = route_table[i].hop_addr;
				best.out_port = route_table[i].port;
				best_mask = route_table[i].mask;
			end
		end
		return best;
	endfunction

	function automatic logic [31:0] len_mask(int unsigned len);
		return (len == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - len));
	endfunction

	function automatic lpr_entry_t route_entry(logic [31:0] prefix, logic [31:0] mask,
			logic [31:0] hop, logic [PORT_W-1:0] port);
		lpr_entry_t e;
		e.prefix = prefix;
		e.mask = mask;
		e.hop_addr = hop;
		e.port = port;
		return e;
	endfunction

	function automatic lpr_entry_t random_route();
		logic [31:0] base;
		logic [31:0] mask;
		int unsigned len;
		base = base_pool[$urandom_range(0, 7)];
		len = $urandom_range(0, 1) ? 8 * $urandom_range(0, 4) : $urandom_range(0, 32);
		mask = len_mask(len);
		// non-contiguous masks, sometimes over an unrelated base
		if ($urandom_range(0, 7) == 0) begin
			mask = $urandom;
			base = $urandom_range(0, 1) ? base : $urandom;
		end
		return route_entry(base & mask, mask, $urandom, PORT_W'($urandom_range(0, 15)));
	endfunction

	function automatic logic [31:0] random_address();
		logic [31:0] keep;
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		keep = len_mask($urandom_range(0, 32));
		return (base_pool[$urandom_range(0, 7)] & keep) | ($urandom & ~keep);
	endfunction

	function automatic lpr_req_t route_write(int unsigned slot, lpr_entry_t e);
		lpr_req_t r;
		r.mode = MODE_WRITE;
		r.entry_index = slot[SLOT_W-1:0];
		r.entry_prefix = e.prefix;
		r.entry_mask = e.mask;
		r.entry_next_hop = e.hop_addr;
		r.entry_port = e.port;
		r.lookup_address = $urandom;
		return r;
	endfunction

	function automatic lpr_req_t route_lookup(logic [31:0] addr);
		lpr_req_t r;
		r.mode = MODE_LOOKUP;
		r.entry_index = SLOT_W'($urandom);
		r.entry_prefix = $urandom;
		r.entry_mask = $urandom;
		r.entry_next_hop = $urandom;
		r.entry_port = PORT_W'($urandom);
		r.lookup_address = addr;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < 40)
			$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic send_item(input lpr_req_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (item.mode == MODE_WRITE) begin
			route_table[item.entry_index] = route_entry(item.entry_prefix, item.entry_mask,
				item.entry_next_hop, item.entry_port);
			writes_sent++;
		end else begin
			expected_routes.push_back(predict_route(item.lookup_address));
			lookups_sent++;
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (expected_routes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_route_count(input int unsigned n);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= n[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		route_count = n;
		cfg_writes++;
	endtask

	// receiver side: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_taken != hold_asks) begin
			hold_taken <= hold_asks;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		lpr_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_routes.size() == 0) begin
				report_mismatch("result with no lookup pending", rsp.next_hop_address, 32'd0);
			end else begin
				want = expected_routes.pop_front();
				if (want.found)
					hits_seen++;
				if (rsp.found !== want.found)
					report_mismatch("found", 32'(rsp.found), 32'(want.found));
				if (rsp.next_hop_address !== want.next_hop_address)
					report_mismatch("next_hop_address", rsp.next_hop_address,
						want.next_hop_address);
				if (rsp.out_port !== want.out_port)
					report_mismatch("out_port", 32'(rsp.out_port), 32'(want.out_port));
			end
		end
	end

	task automatic test_empty_table();
		send_item(route_lookup(32'h0000_0000));
		send_item(route_lookup(32'hFFFF_FFFF));
		wait_drained();
	endtask

	task automatic fill_table();
		for (int unsigned i = 0; i < FILL_SLOTS; i++)
			send_item(route_write(i, random_route()));
		wait_drained();
	endtask

	task automatic test_directed_routes();
		send_item(route_write(0, route_entry(32'h0, 32'h0, 32'h0A00_00FE, 4'd0)));
		send_item(route_write(1, route_entry(32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 4'd15)));
		send_item(route_write(2, route_entry(32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 4'd2)));
		send_item(route_write(3, route_entry(32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0099, 4'd3)));
		send_item(route_write(4, route_entry(32'h0A01_0203, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15)));
		// non-contiguous mask, numerically above /16
		send_item(route_write(5, route_entry(32'h0A01_0003, 32'hFFFF_00FF, 32'h0A01_0005, 4'd5)));
		// prefix outside its mask never matches
		send_item(route_write(6, route_entry(32'hC0A8_0001, 32'hFFFF_FF00, 32'hC0A8_00FE, 4'd6)));
		send_item(route_write(7, route_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'd0)));
		set_route_count(8);
		send_item(route_lookup(32'h0A01_0203));
		send_item(route_lookup(32'h0A01_0903));
		send_item(route_lookup(32'h0A01_0904));
		send_item(route_lookup(32'h0AC8_0001));
		send_item(route_lookup(32'h0B00_0000));
		send_item(route_lookup(32'hFFFF_FFFF));
		send_item(route_lookup(32'hC0A8_0001));
		set_route_count(1);
		send_item(route_lookup(32'h0A01_0203));
		set_route_count(0);
		send_item(route_lookup(32'h0B00_0000));
		wait_drained();
	endtask

	task automatic test_full_table();
		logic [31:0] host;
		host = $urandom;
		send_item(route_write(FILL_SLOTS - 1, route_entry(host, 32'hFFFF_FFFF, $urandom,
			PORT_W'($urandom_range(0, 15)))));
		set_route_count(FILL_SLOTS);
		send_item(route_lookup(host));
		send_item(route_lookup(random_address()));
		set_route_count(FILL_SLOTS - 1);
		send_item(route_lookup(host));
		wait_drained();
	endtask

	task automatic test_result_holdoff();
		set_route_count(6);
		hold_asks++;
		repeat (16)
			send_item(route_lookup(random_address()));
		wait_drained();
	endtask

	task automatic run_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
			input int unsigned items);
		int unsigned sent;
		int unsigned n;
		int unsigned pick;
		int unsigned top;
		sent = 0;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		while (sent < items) begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				n = 0;
			else if (pick < 88)
				n = $urandom_range(1, 40);
			else
				n = $urandom_range(41, FILL_SLOTS);
			set_route_count(n);
			top = (n == 0) ? 0 : n - 1;
			repeat ($urandom_range(10, 30)) begin
				if ($urandom_range(0, 9) < 3)
					send_item(route_write($urandom_range(0, 3) == 0 ?
						$urandom_range(0, DEPTH - 1) : $urandom_range(0, top),
						random_route()));
				else
					send_item(route_lookup(random_address()));
				if ($urandom_range(0, 15) == 0)
					wait_drained();
				sent++;
			end
		end
	endtask

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		foreach (base_pool[i])
			base_pool[i] = $urandom;
		send_idle_pct = 33;
		recv_stall_pct = 85;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_empty_table();
		fill_table();
		test_directed_routes();
		test_full_table();
		run_random_traffic(33, 85, 130);
		run_random_traffic(85, 33, 130);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_result_holdoff();
		run_random_traffic(0, 0, 90);

		wait_drained();
		repeat (32) @(posedge clk);
		if (expected_routes.size() != 0)
			report_mismatch("lookups left without result", 32'(expected_routes.size()), 32'd0);
		$display("covered %0d route writes, %0d lookups with %0d hits, %0d table size settings",
			writes_sent, lookups_sent, hits_seen, cfg_writes);
		$display("table sizes from empty up to every loaded slot, with stalls on both sides");
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
